>>> rtl/sdta_pkg.sv
// ============================================================================
// sdta_pkg
// Shared constants and controller/datapath interface types for the signed
// decimal to ASCII converter.
// ============================================================================
package sdta_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int VALUE_BITS = 32;

    localparam int BCD_W     = 4 * MAX_DIGITS;
    localparam int BIT_CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] CODE_ZERO  = 8'd48;
    localparam logic [7:0] CODE_MINUS = 8'd45;
    localparam logic [7:0] CODE_NINE  = 8'd57;

    typedef struct packed {
        logic load;        // capture a new input word
        logic dabble;      // one shift-and-add-3 step
        logic strip;       // drop one leading zero digit
        logic emit_sign;   // put the minus sign into the output register
        logic emit_digit;  // put the top digit into the output register
    } sdta_cmd_t;

    typedef struct packed {
        logic conv_last;   // the dabble step now running is the final one
        logic top_zero;    // the top BCD digit is zero
        logic one_left;    // exactly one digit remains
        logic neg;         // the captured value is negative
        logic out_free;    // the output register can take a character
    } sdta_status_t;

endpackage

>>> rtl/signed_decimal_to_ascii.sv
// A word is converted and its leading zeros stripped before the first
// character; one character per cycle after that while m_ready stays high.
// A new word is taken only once the last character of the previous one is in
// the output register; conversion is a 32-step bit-serial binary to BCD loop.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ============================================================================
// signed_decimal_to_ascii
// Converts a signed 32-bit word to decimal ASCII text, most significant
// character first, with the last character flagged.
// ============================================================================
module signed_decimal_to_ascii
    import sdta_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_char_code,
    output logic               m_last_char
);

    sdta_cmd_t    cmd;
    sdta_status_t status;

    sdta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sdta_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

endmodule

>>> rtl/sdta_datapath.sv
// ============================================================================
// sdta_datapath
// Magnitude register, bit-serial binary to BCD converter, digit counter and
// the output register of the character channel.
// ============================================================================
module sdta_datapath
    import sdta_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic signed [31:0]  s_value,
    input  sdta_cmd_t           cmd,
    output sdta_status_t        status,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_char_code,
    output logic                m_last_char
);

    logic [VALUE_BITS-1:0] mag_reg,   mag_next;
    logic [BCD_W-1:0]      bcd_reg,   bcd_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]  dig_cnt_reg, dig_cnt_next;
    logic                  neg_reg,   neg_next;
    logic                  valid_reg, valid_next;
    logic [7:0]            code_reg,  code_next;
    logic                  last_reg,  last_next;

    logic [VALUE_BITS-1:0] raw;
    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;

    assign raw       = s_value[VALUE_BITS-1:0];
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Add three to every digit of five or more so that the following left
    // shift doubles the number in decimal.
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    always_comb begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        code_next    = code_reg;
        last_next    = last_reg;
        valid_next   = valid_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        priority if (cmd.load) begin
            neg_next     = raw[VALUE_BITS-1];
            mag_next     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
            bcd_next     = '0;
            bit_cnt_next = '0;
            dig_cnt_next = DIG_CNT_W'(MAX_DIGITS);
        end else if (cmd.dabble) begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end else if (cmd.strip) begin
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end else if (cmd.emit_sign) begin
            code_next  = CODE_MINUS;
            last_next  = 1'b0;
            valid_next = 1'b1;
        end else if (cmd.emit_digit) begin
            code_next    = CODE_ZERO + {4'd0, top_digit};
            last_next    = (dig_cnt_reg == DIG_CNT_W'(1));
            valid_next   = 1'b1;
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end else begin
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        code_reg    <= code_next;
        last_reg    <= last_next;
    end

    assign status.conv_last = (bit_cnt_reg == BIT_CNT_W'(VALUE_BITS - 1));
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.one_left  = (dig_cnt_reg == DIG_CNT_W'(1));
    assign status.neg       = neg_reg;
    assign status.out_free  = !valid_reg || m_ready;

    assign m_valid     = valid_reg;
    assign m_char_code = code_reg;
    assign m_last_char = last_reg;

endmodule

>>> rtl/sdta_ctrl.sv
// ============================================================================
// sdta_ctrl
// Sequencer: load, bit-serial conversion, leading zero removal, then the
// sign (negative values only) and the digits, one word at a time.
// ============================================================================
module sdta_ctrl
    import sdta_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sdta_status_t  status,
    output sdta_cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_STRIP = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.dabble = 1'b1;
                if (status.conv_last) begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                // Keep at least one digit so that zero prints as a single '0'.
                if (status.top_zero && !status.one_left) begin
                    cmd.strip = 1'b1;
                end else if (status.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.one_left) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/sdta_checker.sv
// ============================================================================
// sdta_checker
// Port-level checks on the character channel of the converter.
// ============================================================================
module sdta_checker
    import sdta_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [7:0]         m_char_code,
    input logic               m_last_char
);

    // A stalled word keeps its character.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_code) && $stable(m_last_char))
        else $error("stalled output word changed");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_code == CODE_MINUS)
                    || (m_char_code >= CODE_ZERO && m_char_code <= CODE_NINE))
        else $error("character code is neither a digit nor a minus sign");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_code == CODE_MINUS |-> !m_last_char)
        else $error("minus sign flagged as last character");

    // A new word is never taken while a number is only partly delivered.
    a_no_take_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_char |-> !s_ready)
        else $error("input ready in the middle of a number");

    // Once a word is taken the converter is busy on the next cycle.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after taking a word");

endmodule

bind signed_decimal_to_ascii sdta_checker u_sdta_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_char_code (m_char_code),
    .m_last_char (m_last_char)
);
